>>> design/chunk_set_signature_unit_macros.svh
// ----------------------------------------------------------------------------
// chunk_set_signature_unit assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHUNK_SET_SIGNATURE_UNIT_MACROS_SVH
`define CHUNK_SET_SIGNATURE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the chunk set signature unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package css_pkg;

  // fmix64 finalizer constants
  localparam logic [63:0] FmixMulA   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixMulB   = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FmixShift  = 33;

  // coordinate packing shifts
  localparam int unsigned PackShiftY = 21;
  localparam int unsigned PackShiftZ = 42;

  localparam int unsigned CountWidth = 17;
  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam logic signed [31:0] MinInit = 32'sh7fffffff;
  localparam logic signed [31:0] MaxInit = 32'sh80000000;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } chunk_meta_t;

  typedef struct packed {
    logic [63:0] entry;
    chunk_meta_t meta;
  } mixed_t;

  typedef struct packed {
    logic [63:0]           sig_xor;
    logic [63:0]           sig_sum;
    logic [CountWidth-1:0] set_count;
    logic signed [31:0]    min_x;
    logic signed [31:0]    min_y;
    logic signed [31:0]    min_z;
    logic signed [31:0]    max_x;
    logic signed [31:0]    max_y;
    logic signed [31:0]    max_z;
    logic                  changed;
  } result_t;

endpackage

`default_nettype wire

>>> design/css_ifs.sv
// ----------------------------------------------------------------------------
// css channel interfaces
// Valid/ready channels for chunk items and set signature results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface css_chunk_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] chunk_x;
  logic signed [31:0] chunk_y;
  logic signed [31:0] chunk_z;
  logic [63:0]        revision;
  logic               last_chunk;

  modport source (output valid, chunk_x, chunk_y, chunk_z, revision, last_chunk,
                  input ready);
  modport sink   (input valid, chunk_x, chunk_y, chunk_z, revision, last_chunk,
                  output ready);
endinterface

interface css_sig_if;
  logic                              valid;
  logic                              ready;
  logic [63:0]                       sig_xor;
  logic [63:0]                       sig_sum;
  logic [css_pkg::CountWidth-1:0]    set_count;
  logic signed [31:0]                min_x;
  logic signed [31:0]                min_y;
  logic signed [31:0]                min_z;
  logic signed [31:0]                max_x;
  logic signed [31:0]                max_y;
  logic signed [31:0]                max_z;
  logic                              changed;

  modport source (output valid, sig_xor, sig_sum, set_count, min_x, min_y, min_z,
                  max_x, max_y, max_z, changed, input ready);
  modport sink   (input valid, sig_xor, sig_sum, set_count, min_x, min_y, min_z,
                  max_x, max_y, max_z, changed, output ready);
endinterface

`default_nettype wire

>>> design/css_mixer.sv
// ----------------------------------------------------------------------------
// css_mixer
// Front end: packs coordinates, xors in the revision and runs fmix64 over a
// five-stage pipeline. 64-bit multiplies are split into 32-bit partials.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module css_mixer (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  css_pkg::chunk_meta_t in_meta,
  input  wire [63:0]           in_revision,
  output logic                 mix_valid,
  input  wire                  mix_ready,
  output css_pkg::mixed_t      mix_data
);

  logic                 adv;
  logic [4:0]           stage_v_r, stage_v_nxt;
  css_pkg::chunk_meta_t s0_meta_r, s1_meta_r, s2_meta_r, s3_meta_r, s4_meta_r;
  logic [63:0]          s0_h_r, s2_h_r, s4_h_r;
  logic [63:0]          s1_p0_r, s3_p0_r;
  logic [31:0]          s1_p1_r, s1_p2_r, s3_p1_r, s3_p2_r;

  logic [63:0] packed_w, seed_w, s0_h_nxt;
  logic [63:0] p0a_w, p0b_w;
  logic [31:0] p1a_w, p2a_w, p1b_w, p2b_w;
  logic [63:0] m1_w, m2_w, s2_h_nxt, s4_h_nxt;

  // whole pipe moves together; it only holds when the tail cannot drain
  assign adv      = !stage_v_r[4] || mix_ready;
  assign in_ready = adv;

  assign packed_w = {32'h0, in_meta.x}
                  ^ ({32'h0, in_meta.y} << css_pkg::PackShiftY)
                  ^ ({32'h0, in_meta.z} << css_pkg::PackShiftZ);
  assign seed_w   = packed_w ^ in_revision;
  assign s0_h_nxt = seed_w ^ (seed_w >> css_pkg::FmixShift);

  // low 64 bits of h * C: lo*lo full, cross terms only their low halves
  assign p0a_w = {32'h0, s0_h_r[31:0]} * {32'h0, css_pkg::FmixMulA[31:0]};
  assign p1a_w = s0_h_r[31:0]  * css_pkg::FmixMulA[63:32];
  assign p2a_w = s0_h_r[63:32] * css_pkg::FmixMulA[31:0];

  assign m1_w     = s1_p0_r + {s1_p1_r + s1_p2_r, 32'h0};
  assign s2_h_nxt = m1_w ^ (m1_w >> css_pkg::FmixShift);

  assign p0b_w = {32'h0, s2_h_r[31:0]} * {32'h0, css_pkg::FmixMulB[31:0]};
  assign p1b_w = s2_h_r[31:0]  * css_pkg::FmixMulB[63:32];
  assign p2b_w = s2_h_r[63:32] * css_pkg::FmixMulB[31:0];

  assign m2_w     = s3_p0_r + {s3_p1_r + s3_p2_r, 32'h0};
  assign s4_h_nxt = m2_w ^ (m2_w >> css_pkg::FmixShift);

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (adv) begin
      stage_v_nxt = {stage_v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= '0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_meta_r <= in_meta;
      s0_h_r    <= s0_h_nxt;
      s1_meta_r <= s0_meta_r;
      s1_p0_r   <= p0a_w;
      s1_p1_r   <= p1a_w;
      s1_p2_r   <= p2a_w;
      s2_meta_r <= s1_meta_r;
      s2_h_r    <= s2_h_nxt;
      s3_meta_r <= s2_meta_r;
      s3_p0_r   <= p0b_w;
      s3_p1_r   <= p1b_w;
      s3_p2_r   <= p2b_w;
      s4_meta_r <= s3_meta_r;
      s4_h_r    <= s4_h_nxt;
    end
  end

  assign mix_valid      = stage_v_r[4];
  assign mix_data.entry = s4_h_r;
  assign mix_data.meta  = s4_meta_r;

endmodule

`default_nettype wire

>>> design/css_queue.sv
// ----------------------------------------------------------------------------
// css_queue
// Small FIFO decoupling the mixer pipeline from the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module css_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  css_pkg::mixed_t  push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output css_pkg::mixed_t  pop_data
);

  css_pkg::mixed_t                 slot_r [css_pkg::QueueDepth];
  logic [css_pkg::QueuePtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [css_pkg::QueuePtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [css_pkg::QueuePtrW:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (count_r != (css_pkg::QueuePtrW+1)'(css_pkg::QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/css_accum.sv
// ----------------------------------------------------------------------------
// css_accum
// Back end: folds mixed entries into the running set state, compares with
// the stored signature on the last chunk and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module css_accum #(
  parameter int unsigned MAX_CHUNKS = 65536
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  output logic             q_ready,
  input  css_pkg::mixed_t  q_data,
  output logic             res_valid,
  input  wire              res_ready,
  output css_pkg::result_t res_data
);

  localparam logic [css_pkg::CountWidth-1:0] CountLimit =
    (MAX_CHUNKS > 32'(css_pkg::CountMax)) ? css_pkg::CountMax
                                          : css_pkg::CountWidth'(MAX_CHUNKS);

  logic [63:0]                    acc_xor_r, acc_xor_nxt;
  logic [63:0]                    acc_sum_r, acc_sum_nxt;
  logic [css_pkg::CountWidth-1:0] acc_count_r, acc_count_nxt;
  logic signed [31:0]             min_r [3];
  logic signed [31:0]             max_r [3];
  logic signed [31:0]             min_nxt [3];
  logic signed [31:0]             max_nxt [3];
  logic [63:0]                    ref_xor_r, ref_xor_nxt;
  logic [63:0]                    ref_sum_r, ref_sum_nxt;
  logic [css_pkg::CountWidth-1:0] ref_count_r, ref_count_nxt;
  logic                           ref_valid_r, ref_valid_nxt;
  logic                           res_valid_r, res_valid_nxt;
  css_pkg::result_t               res_r, res_nxt;

  logic [63:0]                    xor_w, sum_w;
  logic [css_pkg::CountWidth-1:0] count_w;
  logic signed [31:0]             coord_w [3];
  logic signed [31:0]             lo_w [3];
  logic signed [31:0]             hi_w [3];
  logic                           pop;

  // a last chunk waits while the previous result is still held
  assign q_ready = !q_data.meta.last || !res_valid_r || res_ready;
  assign pop     = q_valid && q_ready;

  assign coord_w[0] = q_data.meta.x;
  assign coord_w[1] = q_data.meta.y;
  assign coord_w[2] = q_data.meta.z;

  assign xor_w   = acc_xor_r ^ q_data.entry;
  assign sum_w   = acc_sum_r + q_data.entry;
  assign count_w = (acc_count_r < CountLimit) ? acc_count_r + 1'b1 : acc_count_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_w[i] = (coord_w[i] < min_r[i]) ? coord_w[i] : min_r[i];
      hi_w[i] = (coord_w[i] > max_r[i]) ? coord_w[i] : max_r[i];
    end
  end

  always_comb begin
    acc_xor_nxt   = acc_xor_r;
    acc_sum_nxt   = acc_sum_r;
    acc_count_nxt = acc_count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ref_xor_nxt   = ref_xor_r;
    ref_sum_nxt   = ref_sum_r;
    ref_count_nxt = ref_count_r;
    ref_valid_nxt = ref_valid_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;

    if (pop && !q_data.meta.last) begin
      acc_xor_nxt   = xor_w;
      acc_sum_nxt   = sum_w;
      acc_count_nxt = count_w;
      min_nxt       = lo_w;
      max_nxt       = hi_w;
    end else if (pop) begin
      res_valid_nxt     = 1'b1;
      res_nxt.sig_xor   = xor_w;
      res_nxt.sig_sum   = sum_w;
      res_nxt.set_count = count_w;
      res_nxt.min_x     = lo_w[0];
      res_nxt.min_y     = lo_w[1];
      res_nxt.min_z     = lo_w[2];
      res_nxt.max_x     = hi_w[0];
      res_nxt.max_y     = hi_w[1];
      res_nxt.max_z     = hi_w[2];
      res_nxt.changed   = !ref_valid_r || (xor_w != ref_xor_r) ||
                          (sum_w != ref_sum_r) || (count_w != ref_count_r);
      ref_xor_nxt   = xor_w;
      ref_sum_nxt   = sum_w;
      ref_count_nxt = count_w;
      ref_valid_nxt = 1'b1;
      acc_xor_nxt   = '0;
      acc_sum_nxt   = '0;
      acc_count_nxt = '0;
      for (int i = 0; i < 3; i++) begin
        min_nxt[i] = css_pkg::MinInit;
        max_nxt[i] = css_pkg::MaxInit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_xor_r   <= '0;
      acc_sum_r   <= '0;
      acc_count_r <= '0;
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= css_pkg::MinInit;
        max_r[i] <= css_pkg::MaxInit;
      end
      ref_xor_r   <= '0;
      ref_sum_r   <= '0;
      ref_count_r <= '0;
      ref_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      acc_xor_r   <= acc_xor_nxt;
      acc_sum_r   <= acc_sum_nxt;
      acc_count_r <= acc_count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ref_xor_r   <= ref_xor_nxt;
      ref_sum_r   <= ref_sum_nxt;
      ref_count_r <= ref_count_nxt;
      ref_valid_r <= ref_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_data  = res_r;

endmodule

`default_nettype wire

>>> design/chunk_set_signature_unit.sv
// ----------------------------------------------------------------------------
// chunk_set_signature_unit
// Order-independent signature over a set of chunks, one chunk per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  (sink): one chunk per transaction, with x/y/z coordinates, the
//            revision and last_chunk marking the final chunk of a set.
//   out_chan (source): one result per set, presented after the last chunk:
//            xor and sum of the mixed entries, saturating count, per-axis
//            min/max and the changed flag against the previous set.
//   Throughput: one chunk per cycle while the queue accepts, through the five-stage
//   fmix64 pipeline whose two 64-bit multiplies are split into 32-bit partial products.
//   Result path: after a last chunk is accepted it passes the 5 mixer stages,
//   the queue and then the result register before out_chan.valid rises.
//   Reset (rst_n low, synchronous): pipeline and queue empty, accumulators
//   cleared, no stored signature, so the first set reports changed = 1.
//   Receiver stall: the result is held; later non-last chunks keep being
//   accumulated, and a following last chunk waits in the 4-entry queue. Once
//   the queue and pipeline fill, in_chan.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chunk_set_signature_unit #(
  parameter int unsigned MAX_CHUNKS = 65536
) (
  input  wire        clk,
  input  wire        rst_n,
  css_chunk_if.sink  in_chan,
  css_sig_if.source  out_chan
);

  css_pkg::chunk_meta_t in_meta;
  css_pkg::mixed_t      mix_data, q_data;
  css_pkg::result_t     res_data;
  logic                 mix_valid, mix_ready;
  logic                 q_valid, q_ready;

  assign in_meta.x    = in_chan.chunk_x;
  assign in_meta.y    = in_chan.chunk_y;
  assign in_meta.z    = in_chan.chunk_z;
  assign in_meta.last = in_chan.last_chunk;

  css_mixer u_mixer (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_meta     (in_meta),
    .in_revision (in_chan.revision),
    .mix_valid   (mix_valid),
    .mix_ready   (mix_ready),
    .mix_data    (mix_data)
  );

  css_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (mix_valid),
    .push_ready (mix_ready),
    .push_data  (mix_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  css_accum #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready),
    .res_data  (res_data)
  );

  assign out_chan.sig_xor   = res_data.sig_xor;
  assign out_chan.sig_sum   = res_data.sig_sum;
  assign out_chan.set_count = res_data.set_count;
  assign out_chan.min_x     = res_data.min_x;
  assign out_chan.min_y     = res_data.min_y;
  assign out_chan.min_z     = res_data.min_z;
  assign out_chan.max_x     = res_data.max_x;
  assign out_chan.max_y     = res_data.max_y;
  assign out_chan.max_z     = res_data.max_z;
  assign out_chan.changed   = res_data.changed;

endmodule

`default_nettype wire

>>> design/css_checker.sv
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks on the result channel of the signature unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "chunk_set_signature_unit_macros.svh"

module css_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [63:0]                      sig_xor,
  input wire [css_pkg::CountWidth-1:0]   set_count,
  input wire signed [31:0]               min_x,
  input wire signed [31:0]               max_x
);

  `CSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CSS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(sig_xor) && $stable(set_count), "result changed while stalled")
  // every set holds at least its last chunk
  `CSS_ASSERT_SAME(a_count_nonzero, out_valid, set_count != '0, "empty set reported")
  `CSS_ASSERT_SAME(a_bounds_order, out_valid, min_x <= max_x, "min_x above max_x")

endmodule

bind chunk_set_signature_unit css_checker u_css_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .sig_xor   (out_chan.sig_xor),
  .set_count (out_chan.set_count),
  .min_x     (out_chan.min_x),
  .max_x     (out_chan.max_x)
);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: chunk_set_signature_unit testbench
// Drives chunk sets through the input channel under several idle/stall
// patterns. An in-bench model of the mixer, accumulators and stored signature
// predicts each set result; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_CHUNKS     = 65536;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned PHASE_ITEMS    = 175;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [63:0]        rev;
  } chunk_item_t;

  class signature_board;
    int unsigned      count_cap;
    bit [63:0]        acc_xor;
    bit [63:0]        acc_sum;
    bit [16:0]        acc_count;
    bit signed [31:0] lo_c[3];
    bit signed [31:0] hi_c[3];
    bit [63:0]        kept_xor;
    bit [63:0]        kept_sum;
    bit [16:0]        kept_count;
    bit               kept_valid;
    css_pkg::result_t expected_sigs[$];
    int               errors;

    function new(int unsigned max_chunks);
      // count register is 17 bits wide, so the cap never exceeds its range
      count_cap  = (max_chunks > 131071) ? 131071 : max_chunks;
      kept_xor   = '0;
      kept_sum   = '0;
      kept_count = '0;
      kept_valid = 1'b0;
      errors     = 0;
      clear_set();
    endfunction

    function void clear_set();
      acc_xor   = '0;
      acc_sum   = '0;
      acc_count = '0;
      for (int i = 0; i < 3; i++) begin
        lo_c[i] = 32'sh7fffffff;
        hi_c[i] = 32'sh80000000;
      end
    endfunction

    static function bit [63:0] pack_coords(bit [31:0] x, bit [31:0] y, bit [31:0] z);
      return {32'h0, x} ^ ({32'h0, y} << 21) ^ ({32'h0, z} << 42);
    endfunction

    // 64-bit murmur3 finalizer
    static function bit [63:0] fmix(bit [63:0] h);
      h ^= h >> 33;
      h = h * 64'hff51afd7ed558ccd;
      h ^= h >> 33;
      h = h * 64'hc4ceb9fe1a85ec53;
      h ^= h >> 33;
      return h;
    endfunction

    function int pending();
      return expected_sigs.size();
    endfunction

    task note_chunk(bit signed [31:0] x, bit signed [31:0] y, bit signed [31:0] z,
                    bit [63:0] rev, bit last);
      bit signed [31:0] c[3];
      bit [63:0]        entry;
      css_pkg::result_t r;
      c[0]  = x;
      c[1]  = y;
      c[2]  = z;
      entry = fmix(pack_coords(x, y, z) ^ rev);
      acc_xor ^= entry;
      acc_sum += entry;
      if (acc_count < count_cap) acc_count++;
      for (int i = 0; i < 3; i++) begin
        if (c[i] < lo_c[i]) lo_c[i] = c[i];
        if (c[i] > hi_c[i]) hi_c[i] = c[i];
      end
      if (last) begin
        r.sig_xor   = acc_xor;
        r.sig_sum   = acc_sum;
        r.set_count = acc_count;
        r.min_x     = lo_c[0];
        r.min_y     = lo_c[1];
        r.min_z     = lo_c[2];
        r.max_x     = hi_c[0];
        r.max_y     = hi_c[1];
        r.max_z     = hi_c[2];
        r.changed   = !kept_valid || kept_xor != acc_xor || kept_sum != acc_sum ||
                      kept_count != acc_count;
        expected_sigs = {expected_sigs, r};
        kept_xor   = acc_xor;
        kept_sum   = acc_sum;
        kept_count = acc_count;
        kept_valid = 1'b1;
        clear_set();
      end
    endtask

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(css_pkg::result_t got);
      css_pkg::result_t want;
      if (expected_sigs.size() == 0) begin
        report("result transaction with no set pending");
        return;
      end
      want = expected_sigs[0];
      expected_sigs.delete(0);
      check_field("sig_xor",   got.sig_xor,   want.sig_xor);
      check_field("sig_sum",   got.sig_sum,   want.sig_sum);
      check_field("set_count", got.set_count, want.set_count);
      check_field("min_x",     got.min_x,     want.min_x);
      check_field("min_y",     got.min_y,     want.min_y);
      check_field("min_z",     got.min_z,     want.min_z);
      check_field("max_x",     got.max_x,     want.max_x);
      check_field("max_y",     got.max_y,     want.max_y);
      check_field("max_z",     got.max_z,     want.max_z);
      check_field("changed",   got.changed,   want.changed);
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   stall_pct;
  signature_board sb;

  css_chunk_if in_if ();
  css_sig_if   out_if ();

  chunk_set_signature_unit #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checked before the input is noted, so a last chunk accepted on
  // the same edge never matches the result leaving on it
  always @(posedge clk) begin : monitor
    css_pkg::result_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.sig_xor   = out_if.sig_xor;
        got.sig_sum   = out_if.sig_sum;
        got.set_count = out_if.set_count;
        got.min_x     = out_if.min_x;
        got.min_y     = out_if.min_y;
        got.min_z     = out_if.min_z;
        got.max_x     = out_if.max_x;
        got.max_y     = out_if.max_y;
        got.max_z     = out_if.max_z;
        got.changed   = out_if.changed;
        sb.check_result(got);
      end
      if (in_if.valid && in_if.ready)
        sb.note_chunk(in_if.chunk_x, in_if.chunk_y, in_if.chunk_z, in_if.revision,
                      in_if.last_chunk);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_if.valid && in_if.ready) && !(out_if.valid && out_if.ready))
        quiet_cycles++;
      else
        quiet_cycles = 0;
    end
    $display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** chunk_set_signature_unit: FAILED **");
    $finish;
  end

  task automatic send_chunk(chunk_item_t c, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.chunk_x    <= c.x;
    in_if.chunk_y    <= c.y;
    in_if.chunk_z    <= c.z;
    in_if.revision   <= c.rev;
    in_if.last_chunk <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_set(chunk_item_t s[$]);
    foreach (s[i]) send_chunk(s[i], i == s.size() - 1);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(9))
      0:       return 32'sh80000000;
      1:       return 32'sh7fffffff;
      2:       return -32'sd1;
      3, 4:    return $signed($urandom_range(16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic chunk_item_t random_chunk();
    chunk_item_t c;
    c.x   = random_coord();
    c.y   = random_coord();
    c.z   = random_coord();
    c.rev = $urandom_range(3) == 0 ? 64'($urandom_range(15)) : {$urandom, $urandom};
    return c;
  endfunction

  function automatic chunk_item_t mk(logic signed [31:0] x, logic signed [31:0] y,
                                     logic signed [31:0] z, logic [63:0] rev);
    chunk_item_t c;
    c.x   = x;
    c.y   = y;
    c.z   = z;
    c.rev = rev;
    return c;
  endfunction

  initial begin : stimulus
    chunk_item_t cur[$];
    chunk_item_t prev[$];
    int          idle_tab[4];
    int          stall_tab[4];
    int          sent;
    int          len;

    sb = new(MAX_CHUNKS);
    idle_tab  = '{0, 79, 0, 36};
    stall_tab = '{0, 0, 79, 36};
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.chunk_x    <= '0;
    in_if.chunk_y    <= '0;
    in_if.chunk_z    <= '0;
    in_if.revision   <= '0;
    in_if.last_chunk <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first set after reset: changed must be set; the repeat must clear it
    cur = '{mk(0, 0, 0, 64'h0)};
    send_set(cur);
    send_set(cur);

    // coordinate and revision extremes, then the same set in reverse order
    cur = '{mk(32'sh80000000, 32'sh7fffffff, -32'sd1, 64'hffffffffffffffff),
            mk(32'sh7fffffff, 32'sh80000000, 32'sd0, 64'h0),
            mk(32'sd1, -32'sd2, 32'sd3, 64'h8000000000000000)};
    send_set(cur);
    cur.reverse();
    send_set(cur);

    // coordinates equal to a bound's start value, so that bound stays put
    send_set('{mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 64'h5555555555555555)});
    send_set('{mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 64'haaaaaaaaaaaaaaaa)});

    // duplicate chunks cancel in the xor
    cur = '{mk(32'sd12345, -32'sd6789, 32'sd42, 64'h0123456789abcdef),
            mk(32'sd12345, -32'sd6789, 32'sd42, 64'h0123456789abcdef)};
    send_set(cur);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      stall_pct     = stall_tab[ph];
      sent = 0;
      prev = {};
      while (sent < PHASE_ITEMS) begin
        if (prev.size() != 0 && $urandom_range(4) == 0) begin
          // reordered resend of the last set: signature must be unchanged
          cur = prev;
          cur.reverse();
        end else begin
          len = ($urandom_range(3) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
          cur = {};
          repeat (len) cur = {cur, random_chunk()};
        end
        send_set(cur);
        sent += cur.size();
        prev = cur;
      end
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("** chunk_set_signature_unit: PASSED **");
    else
      $display("** chunk_set_signature_unit: FAILED **");
    $finish;
  end

endmodule
